FILE: rtl/core/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// bfpa_pkg: shared codes and constants for the best-fit page allocator
// Opcode and status codes, shared by the control and the top level.
// ----------------------------------------------------------------------------
package bfpa_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_RUN    = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_BAD_SIZE  = 2'd3;

   localparam logic [31:0] HEAP_BASE_RESET = 32'h8000_0000;

endpackage

FILE: rtl/core/bfpa_ram.sv
// ----------------------------------------------------------------------------
// bfpa_ram: generic single-port-write, one-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/best_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_page_allocator: best-fit page allocator over a page bitmap
// Bitmap, table starts and table counts each live in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel: tuser = opcode (0 allocate, 1 free); tdata = size_bytes in
//  [22:0], address in [54:23], zero-padded to 56 bits.
//  rsp_ channel: tdata = result_address [31:0], status [33:32], padded to 40.
//  csr_: write csr_wr_en with csr_wr_data to set heap_base at any idle time.
//  One request is in work at a time; req_tready is low while busy.
//  Allocate: a bitmap scan over all pages, one page per cycle (single read
//  port of the bitmap RAM), then the pages of the best run are marked.
//  Free: each live table entry searched takes a table RAM read, then a
//  compare; then the pages of the run are cleared, and the last entry is
//  moved into the freed slot (read, then write).
//  Reset: a clearing pass writes zero to every bitmap entry, one per cycle,
//  with req_tready low. The table needs no clearing.
//  A stalled response is held in the output register; the next request is
//  accepted once the response has been taken.
// ----------------------------------------------------------------------------
module best_fit_page_allocator #(
   parameter int NUM_PAGES  = 1024,
   parameter int PAGE_SHIFT = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // size_bytes[22:0], address[54:23]
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // result_address[31:0], status[33:32]
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int CW = $clog2(NUM_PAGES + 2);   // holds NUM_PAGES+1

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_SCAN  = 10'b0000000100,
      S_MARK  = 10'b0000001000,
      S_FIND  = 10'b0000010000,
      S_FCHK  = 10'b0000100000,
      S_UNMK  = 10'b0001000000,
      S_MVRD  = 10'b0010000000,
      S_MVWR  = 10'b0100000000,
      S_RESP  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] base_ff;
   logic [CW-1:0] idx_ff, idx_in;        // scan / search / mark index
   logic [CW-1:0] run_ff, run_in, best_ff, best_in, req_ff, req_in;
   logic [AW-1:0] run_st_ff, run_st_in, best_st_ff, best_st_in;
   logic [CW-1:0] ent_ff, ent_in;        // alloc_entries
   logic [CW-1:0] hit_ff, hit_in;        // matching entry
   logic [AW-1:0] pg_ff, pg_in;          // mark/unmark page
   logic [CW-1:0] cnt_ff, cnt_in;        // pages left to mark or unmark
   logic [31:0] addr_ff, addr_in;
   logic [31:0] res_ff, res_in;
   logic [1:0]  st_ff, st_in;

   // RAM ports
   logic          bm_we, bm_wd, bm_rd;
   logic [AW-1:0] bm_wa, bm_ra;
   logic          tb_we;
   logic [AW-1:0] tb_wa, tb_ra;
   logic [AW-1:0] ts_wd, ts_rd;
   logic [CW-1:0] tc_wd, tc_rd;

   bfpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_bitmap (
      .clock, .wr_en(bm_we), .wr_addr(bm_wa), .wr_data(bm_wd),
      .rd_addr(bm_ra), .rd_data(bm_rd));
   bfpa_ram #(.WIDTH(AW), .DEPTH(NUM_PAGES)) u_start (
      .clock, .wr_en(tb_we), .wr_addr(tb_wa), .wr_data(ts_wd),
      .rd_addr(tb_ra), .rd_data(ts_rd));
   bfpa_ram #(.WIDTH(CW), .DEPTH(NUM_PAGES)) u_count (
      .clock, .wr_en(tb_we), .wr_addr(tb_wa), .wr_data(tc_wd),
      .rd_addr(tb_ra), .rd_data(tc_rd));

   logic [22:0] in_size;
   logic [23:0] size_rnd;
   logic [23-PAGE_SHIFT:0] need_pages;
   logic [31:0] page_off;

   assign in_size    = req_tdata[22:0];
   assign size_rnd   = {1'b0, in_size} + 24'((1 << PAGE_SHIFT) - 1);
   assign need_pages = size_rnd[23:PAGE_SHIFT];
   assign page_off   = 32'(ts_rd) << PAGE_SHIFT;

   assign req_tready = (state_ff == S_IDLE) && !rsp_tvalid;
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {6'd0, st_ff, res_ff};

   logic free_pg;
   assign free_pg = (idx_ff <= CW'(NUM_PAGES)) && (idx_ff != 0) &&
                    (idx_ff - 1'b1 < CW'(NUM_PAGES)) && !bm_rd;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff; run_in = run_ff; best_in = best_ff; req_in = req_ff;
      run_st_in = run_st_ff; best_st_in = best_st_ff; ent_in = ent_ff;
      hit_in = hit_ff; pg_in = pg_ff; cnt_in = cnt_ff; addr_in = addr_ff;
      res_in = res_ff; st_in = st_ff;
      bm_we = 1'b0; bm_wa = pg_ff; bm_wd = 1'b0;
      bm_ra = idx_ff[AW-1:0];
      tb_we = 1'b0; tb_wa = hit_ff[AW-1:0]; tb_ra = idx_ff[AW-1:0];
      ts_wd = ts_rd; tc_wd = tc_rd;
      case (state_ff)
         S_CLEAR: begin
            // sweep the bitmap to zero after reset
            bm_we = 1'b1; bm_wa = idx_ff[AW-1:0];
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CW'(NUM_PAGES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               idx_in = '0; run_in = '0; best_in = CW'(NUM_PAGES + 1);
               res_in = '0; addr_in = req_tdata[54:23];
               if (req_tuser == bfpa_pkg::OP_FREE) begin
                  state_in = S_FIND;
               end else if (in_size == 0 ||
                            32'(need_pages) > 32'(NUM_PAGES)) begin
                  st_in = bfpa_pkg::ST_BAD_SIZE; state_in = S_RESP;
               end else begin
                  req_in = CW'(need_pages); state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // idx_ff is the read address; page idx_ff-1 data is on bm_rd
            idx_in = idx_ff + 1'b1;
            if (idx_ff != 0) begin
               if (free_pg) begin
                  if (run_ff == 0) run_st_in = AW'(idx_ff - 1'b1);
                  run_in = run_ff + 1'b1;
               end else begin
                  if (run_ff >= req_ff && run_ff < best_ff) begin
                     best_in = run_ff; best_st_in = run_st_ff;
                  end
                  run_in = '0;
               end
            end
            if (idx_ff == CW'(NUM_PAGES + 1)) begin
               if (best_in > CW'(NUM_PAGES) || ent_ff >= CW'(NUM_PAGES)) begin
                  st_in = bfpa_pkg::ST_NO_RUN; state_in = S_RESP;
               end else begin
                  pg_in = best_in == best_ff ? best_st_ff : best_st_in;
                  cnt_in = req_ff; state_in = S_MARK;
               end
            end
         end
         S_MARK: begin
            bm_we = 1'b1; bm_wd = 1'b1;
            pg_in = pg_ff + 1'b1; cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 1) begin
               tb_we = 1'b1; tb_wa = ent_ff[AW-1:0];
               ts_wd = best_st_ff; tc_wd = req_ff;
               ent_in = ent_ff + 1'b1;
               res_in = base_ff + (32'(best_st_ff) << PAGE_SHIFT);
               st_in = bfpa_pkg::ST_OK; state_in = S_RESP;
            end
         end
         S_FIND: begin
            // issue table read at idx_ff
            if (idx_ff >= ent_ff) begin
               st_in = bfpa_pkg::ST_NOT_FOUND; state_in = S_RESP;
            end else begin
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (base_ff + page_off == addr_ff) begin
               hit_in = idx_ff; pg_in = ts_rd; cnt_in = tc_rd;
               state_in = S_UNMK;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = S_FIND;
            end
         end
         S_UNMK: begin
            bm_we = 1'b1; bm_wd = 1'b0;
            pg_in = pg_ff + 1'b1; cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 1 || pg_ff == AW'(NUM_PAGES - 1)) state_in = S_MVRD;
         end
         S_MVRD: begin
            tb_ra = AW'(ent_ff - 1'b1);
            state_in = S_MVWR;
         end
         S_MVWR: begin
            tb_we = 1'b1;
            ent_in = ent_ff - 1'b1;
            st_in = bfpa_pkg::ST_OK; state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         ent_ff   <= '0;
         base_ff  <= bfpa_pkg::HEAP_BASE_RESET;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         ent_ff   <= ent_in;
         if (csr_wr_en) base_ff <= csr_wr_data;
      end
      run_ff <= run_in; best_ff <= best_in; req_ff <= req_in;
      run_st_ff <= run_st_in; best_st_ff <= best_st_in;
      hit_ff <= hit_in; pg_ff <= pg_in; cnt_ff <= cnt_in;
      addr_ff <= addr_in; res_ff <= res_in; st_ff <= st_in;
   end
endmodule
